### hw/rtl/sgcd_pkg.sv
// Shared constants, types and codes for the safegcd modular inverse unit.
`timescale 1ns / 1ps

package sgcd_pkg;

  // Default sizes of the datapath.
  localparam int MOD_BITS_DEF = 62;
  localparam int EXT_BITS_DEF = 64;
  localparam int DIVSTEPS_DEF = 62;

  // Fixed widths of the interface and of the internal words.
  localparam int FIELD_W = 62;
  localparam int WORD_W = 64;
  localparam int ACC_W = 128;
  localparam int HALF_W = 32;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 5;

  // Round limit and the constants of the batched elimination.
  localparam int ROUND_CAP = 256;
  localparam int ROUND_W = 9;
  localparam int BATCH_MAX = 5;
  localparam int BATCH_W = 5;
  localparam int W_XOR = 28;
  localparam int W_MUL = 3;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_MODULUS = 2'd0,
    REG_MOD_INV = 2'd1,
    REG_MONT    = 2'd2,
    REG_R2      = 2'd3
  } sgcd_reg_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_RCHK,
    S_JSHIFT,
    S_JBATCH,
    S_UISSUE,
    S_UWAIT,
    S_FIN1,
    S_FIN2,
    S_FIN3,
    S_DONE
  } sgcd_state_t;

  // Multiply-accumulate program of one matrix update round.
  typedef enum logic [3:0] {
    U_F_T0,
    U_G_T1,
    U_F_T2,
    U_G_T3,
    U_T0_DL,
    U_T1_EL,
    U_CD_INV,
    U_T2_DL,
    U_T3_EL,
    U_CE_INV,
    U_D_T0,
    U_E_T1,
    U_M_MD,
    U_D_T2,
    U_E_T3,
    U_M_ME
  } sgcd_uop_t;

  // Multiply unit step codes.
  typedef enum logic [2:0] {
    M_LL   = 3'd0,
    M_LH   = 3'd1,
    M_HL   = 3'd2,
    M_HH   = 3'd3,
    M_CORR = 3'd4
  } sgcd_mstep_t;

  // Request from the sequencer to the multiply unit.
  typedef struct packed {
    logic              start;
    logic              clr;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } sgcd_mac_req_t;

  // Status from the multiply unit.
  typedef struct packed {
    logic busy;
    logic done;
  } sgcd_mac_st_t;

endpackage

### hw/rtl/safegcd_modular_inverse_unit.sv
// Top level of the safegcd modular inverse unit: register port, sequencer, divstep datapath.
`timescale 1ns / 1ps

// One word in gives one word out: operand^-1 mod modulus (times R^2 in Montgomery
// mode), or zero when the operand has no inverse. The unit works on one word at
// a time and holds in_ready low while busy; a finished result waits in the
// output register, so the next word can be taken meanwhile. Each round opens,
// skips zero bits (at most DIVSTEPS in all), runs eliminations and closes the
// jump, then runs sixteen 64x64 multiplies on the shared 32x32 multiplier.
// Finishing adds a closing round check, normalization in S_FIN1, S_FIN2 and
// S_FIN3 and a hand-off state. At most ROUND_CAP rounds run.
// Program modulus, its inverse modulo 2^DIVSTEPS, the mode and R^2 before
// sending words.
module safegcd_modular_inverse_unit #(
  parameter int MOD_BITS = sgcd_pkg::MOD_BITS_DEF,
  parameter int EXT_BITS = sgcd_pkg::EXT_BITS_DEF,
  parameter int DIVSTEPS = sgcd_pkg::DIVSTEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [sgcd_pkg::FIELD_W-1:0]      in_operand,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [sgcd_pkg::FIELD_W-1:0]      out_inverse,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sgcd_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [sgcd_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [sgcd_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);

  localparam int SW = $clog2(DIVSTEPS + 1);
  localparam int WW = sgcd_pkg::WORD_W;
  localparam logic [WW-1:0] NM = (WW'(1) << DIVSTEPS) - WW'(1);

  // Configuration registers.
  logic [sgcd_pkg::FIELD_W-1:0] mod_r;
  logic [sgcd_pkg::FIELD_W-1:0] inv_r;
  logic                         mont_r;
  logic [sgcd_pkg::FIELD_W-1:0] r2_r;

  // Sequencer and datapath state.
  sgcd_pkg::sgcd_state_t state_r, state_nxt;
  sgcd_pkg::sgcd_uop_t   uop_r;
  logic [EXT_BITS-1:0] f_r, g_r, d_r, e_r, m_r;
  logic [EXT_BITS-1:0] nf_r, ng_r, dn_r, res_r;
  logic [WW-1:0] eta_r, et_r, fl_r, gl_r;
  logic [WW-1:0] t00_r, t01_r, t10_r, t11_r;
  logic [WW-1:0] c_r, md_r, me_r;
  logic [SW-1:0] steps_r, bodies_r;
  logic [sgcd_pkg::ROUND_W-1:0] rounds_r;
  logic out_valid_r;
  logic [sgcd_pkg::FIELD_W-1:0] out_inverse_r;

  // Multiply unit link.
  sgcd_pkg::sgcd_mac_req_t mac_req;
  sgcd_pkg::sgcd_mac_st_t  mac_st;
  logic [sgcd_pkg::ACC_W-1:0] mac_acc;

  // Combinational helpers.
  logic [WW-1:0] f64, g64, d64, e64, m64;
  logic [WW-1:0] te0, te1, te2, te3;
  logic [WW-1:0] md0, me0, md_ext, me_ext;
  logic [WW-1:0] a1, mn;
  logic [2:0] sh;
  logic [sgcd_pkg::BATCH_W-1:0] f3, wx, wprod, wmask, w;
  logic [WW-1:0] mod_sel, op_sel, r2_sel;
  logic j_more, j_end, do_swap, in_fire, fin_ok, fin_anti;
  logic [WW-1:0] res64;

  // Configuration port.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r  <= sgcd_pkg::FIELD_W'(3);
      inv_r  <= '0;
      mont_r <= 1'b0;
      r2_r   <= '0;
    end else if (psel && penable && pwrite) begin
      case (sgcd_pkg::sgcd_reg_t'(paddr[4:3]))
        sgcd_pkg::REG_MODULUS: mod_r  <= pwdata[sgcd_pkg::FIELD_W-1:0];
        sgcd_pkg::REG_MOD_INV: inv_r  <= pwdata[sgcd_pkg::FIELD_W-1:0];
        sgcd_pkg::REG_MONT:    mont_r <= pwdata[0];
        sgcd_pkg::REG_R2:      r2_r   <= pwdata[sgcd_pkg::FIELD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sgcd_pkg::sgcd_reg_t'(paddr[4:3]))
      sgcd_pkg::REG_MODULUS: prdata = sgcd_pkg::CFG_DATA_W'(mod_r);
      sgcd_pkg::REG_MOD_INV: prdata = sgcd_pkg::CFG_DATA_W'(inv_r);
      sgcd_pkg::REG_MONT:    prdata = sgcd_pkg::CFG_DATA_W'(mont_r);
      sgcd_pkg::REG_R2:      prdata = sgcd_pkg::CFG_DATA_W'(r2_r);
      default:               prdata = '0;
    endcase
  end

  // Sign-extended views and the low MOD_BITS of the loaded values.
  always_comb begin
    f64 = WW'(signed'(f_r));
    g64 = WW'(signed'(g_r));
    d64 = WW'(signed'(d_r));
    e64 = WW'(signed'(e_r));
    m64 = WW'(signed'(m_r));
    te0 = WW'(signed'(t00_r[EXT_BITS-1:0]));
    te1 = WW'(signed'(t01_r[EXT_BITS-1:0]));
    te2 = WW'(signed'(t10_r[EXT_BITS-1:0]));
    te3 = WW'(signed'(t11_r[EXT_BITS-1:0]));
    md_ext = WW'(signed'(md_r[EXT_BITS-1:0]));
    me_ext = WW'(signed'(me_r[EXT_BITS-1:0]));
    md0 = (d_r[EXT_BITS-1] ? t00_r : '0) + (e_r[EXT_BITS-1] ? t01_r : '0);
    me0 = (d_r[EXT_BITS-1] ? t10_r : '0) + (e_r[EXT_BITS-1] ? t11_r : '0);
    mod_sel = WW'(mod_r[MOD_BITS-1:0]);
    op_sel  = WW'(in_operand[MOD_BITS-1:0]);
    r2_sel  = WW'(r2_r[MOD_BITS-1:0]);
    res64 = WW'(signed'(res_r));
    fin_anti = &f_r;
    fin_ok = (g_r == '0) && ((f_r == EXT_BITS'(1)) || fin_anti);
  end

  // Divstep decisions: zero skipping, end of jump and the swap.
  always_comb begin
    j_more  = (steps_r != '0) && !gl_r[0];
    j_end   = (steps_r == '0) || (bodies_r >= SW'(DIVSTEPS));
    do_swap = (et_r != '0) && !et_r[WW-1];
  end

  // Width of the batched elimination and its multiplier w.
  always_comb begin
    a1 = WW'(1) - et_r;
    mn = (a1 < WW'(steps_r)) ? a1 : WW'(steps_r);
    if (a1[WW-1] || (a1 == '0)) begin
      sh = 3'd0;
    end else if (mn > WW'(sgcd_pkg::BATCH_MAX)) begin
      sh = 3'(sgcd_pkg::BATCH_MAX);
    end else begin
      sh = mn[2:0];
    end
    f3    = sgcd_pkg::BATCH_W'(fl_r[sgcd_pkg::BATCH_W-1:0] * sgcd_pkg::BATCH_W'(sgcd_pkg::W_MUL));
    wx    = f3 ^ sgcd_pkg::BATCH_W'(sgcd_pkg::W_XOR);
    wprod = sgcd_pkg::BATCH_W'(gl_r[sgcd_pkg::BATCH_W-1:0] * wx);
    wmask = sgcd_pkg::BATCH_W'((6'd1 << sh) - 6'd1);
    w     = wprod & wmask;
  end

  // Operand selection for the multiply program.
  always_comb begin
    mac_req.start = (state_r == sgcd_pkg::S_UISSUE);
    mac_req.clr = 1'b0;
    mac_req.a = '0;
    mac_req.b = '0;
    case (uop_r)
      sgcd_pkg::U_F_T0:   begin mac_req.clr = 1'b1; mac_req.a = f64; mac_req.b = te0; end
      sgcd_pkg::U_G_T1:   begin mac_req.a = g64; mac_req.b = te1; end
      sgcd_pkg::U_F_T2:   begin mac_req.clr = 1'b1; mac_req.a = f64; mac_req.b = te2; end
      sgcd_pkg::U_G_T3:   begin mac_req.a = g64; mac_req.b = te3; end
      sgcd_pkg::U_T0_DL:  begin mac_req.clr = 1'b1; mac_req.a = t00_r; mac_req.b = d64 & NM; end
      sgcd_pkg::U_T1_EL:  begin mac_req.a = t01_r; mac_req.b = e64 & NM; end
      sgcd_pkg::U_CD_INV: begin mac_req.clr = 1'b1; mac_req.a = c_r; mac_req.b = WW'(inv_r); end
      sgcd_pkg::U_T2_DL:  begin mac_req.clr = 1'b1; mac_req.a = t10_r; mac_req.b = d64 & NM; end
      sgcd_pkg::U_T3_EL:  begin mac_req.a = t11_r; mac_req.b = e64 & NM; end
      sgcd_pkg::U_CE_INV: begin mac_req.clr = 1'b1; mac_req.a = c_r; mac_req.b = WW'(inv_r); end
      sgcd_pkg::U_D_T0:   begin mac_req.clr = 1'b1; mac_req.a = d64; mac_req.b = te0; end
      sgcd_pkg::U_E_T1:   begin mac_req.a = e64; mac_req.b = te1; end
      sgcd_pkg::U_M_MD:   begin mac_req.a = m64; mac_req.b = md_ext; end
      sgcd_pkg::U_D_T2:   begin mac_req.clr = 1'b1; mac_req.a = d64; mac_req.b = te2; end
      sgcd_pkg::U_E_T3:   begin mac_req.a = e64; mac_req.b = te3; end
      sgcd_pkg::U_M_ME:   begin mac_req.a = m64; mac_req.b = me_ext; end
      default: ;
    endcase
  end

  sgcd_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mac_req),
    .st    (mac_st),
    .acc   (mac_acc)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sgcd_pkg::S_IDLE:   if (in_valid) state_nxt = sgcd_pkg::S_RCHK;
      sgcd_pkg::S_RCHK: begin
        if ((g_r != '0) && (rounds_r < sgcd_pkg::ROUND_W'(sgcd_pkg::ROUND_CAP))) begin
          state_nxt = sgcd_pkg::S_JSHIFT;
        end else begin
          state_nxt = sgcd_pkg::S_FIN1;
        end
      end
      sgcd_pkg::S_JSHIFT: begin
        if (!j_more) begin
          state_nxt = j_end ? sgcd_pkg::S_UISSUE : sgcd_pkg::S_JBATCH;
        end
      end
      sgcd_pkg::S_JBATCH: state_nxt = sgcd_pkg::S_JSHIFT;
      sgcd_pkg::S_UISSUE: state_nxt = sgcd_pkg::S_UWAIT;
      sgcd_pkg::S_UWAIT: begin
        if (mac_st.done) begin
          state_nxt = (uop_r == sgcd_pkg::U_M_ME) ? sgcd_pkg::S_RCHK : sgcd_pkg::S_UISSUE;
        end
      end
      sgcd_pkg::S_FIN1:   state_nxt = sgcd_pkg::S_FIN2;
      sgcd_pkg::S_FIN2:   state_nxt = sgcd_pkg::S_FIN3;
      sgcd_pkg::S_FIN3:   state_nxt = sgcd_pkg::S_DONE;
      sgcd_pkg::S_DONE:   if (!out_valid_r || out_ready) state_nxt = sgcd_pkg::S_IDLE;
      default:            state_nxt = sgcd_pkg::S_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_ready = (state_r == sgcd_pkg::S_IDLE);
    in_fire  = in_valid && in_ready;
  end

  assign out_valid   = out_valid_r;
  assign out_inverse = out_inverse_r;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sgcd_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == sgcd_pkg::S_DONE && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      sgcd_pkg::S_IDLE: begin
        if (in_fire) begin
          m_r <= mod_sel[EXT_BITS-1:0];
          f_r <= mod_sel[EXT_BITS-1:0];
          g_r <= op_sel[EXT_BITS-1:0];
          d_r <= '0;
          e_r <= mont_r ? r2_sel[EXT_BITS-1:0] : EXT_BITS'(1);
          eta_r <= WW'(1);
          rounds_r <= '0;
        end
      end
      sgcd_pkg::S_RCHK: begin
        // Open a round: identity matrix on the low bits of f and g.
        rounds_r <= rounds_r + 1'b1;
        fl_r <= f64 & NM;
        gl_r <= g64 & NM;
        t00_r <= WW'(1);
        t01_r <= '0;
        t10_r <= '0;
        t11_r <= WW'(1);
        steps_r <= SW'(DIVSTEPS);
        bodies_r <= '0;
        et_r <= eta_r;
        uop_r <= sgcd_pkg::U_F_T0;
      end
      sgcd_pkg::S_JSHIFT: begin
        if (j_more) begin
          steps_r <= steps_r - 1'b1;
          et_r <= et_r + WW'(1);
          gl_r <= gl_r >> 1;
          t00_r <= t00_r << 1;
          t01_r <= t01_r << 1;
        end else if (j_end) begin
          eta_r <= et_r;
        end else begin
          bodies_r <= bodies_r + 1'b1;
          if (do_swap) begin
            et_r <= '0 - et_r;
            t10_r <= '0 - t00_r;
            t11_r <= '0 - t01_r;
            t00_r <= t10_r;
            t01_r <= t11_r;
            gl_r <= '0 - fl_r;
            fl_r <= gl_r;
          end
        end
      end
      sgcd_pkg::S_JBATCH: begin
        t10_r <= t10_r + t00_r * WW'(w);
        t11_r <= t11_r + t01_r * WW'(w);
        gl_r <= gl_r + fl_r * WW'(w);
      end
      sgcd_pkg::S_UWAIT: begin
        if (mac_st.done) begin
          uop_r <= sgcd_pkg::sgcd_uop_t'(uop_r + 4'd1);
          case (uop_r)
            sgcd_pkg::U_G_T1:   nf_r <= mac_acc[DIVSTEPS +: EXT_BITS];
            sgcd_pkg::U_G_T3:   ng_r <= mac_acc[DIVSTEPS +: EXT_BITS];
            sgcd_pkg::U_T1_EL:  c_r <= mac_acc[WW-1:0] & NM;
            sgcd_pkg::U_CD_INV: md_r <= md0 - ((mac_acc[WW-1:0] + md0) & NM);
            sgcd_pkg::U_T3_EL:  c_r <= mac_acc[WW-1:0] & NM;
            sgcd_pkg::U_CE_INV: me_r <= me0 - ((mac_acc[WW-1:0] + me0) & NM);
            sgcd_pkg::U_M_MD:   dn_r <= mac_acc[DIVSTEPS +: EXT_BITS];
            sgcd_pkg::U_M_ME: begin
              f_r <= nf_r;
              g_r <= ng_r;
              d_r <= dn_r;
              e_r <= mac_acc[DIVSTEPS +: EXT_BITS];
            end
            default: ;
          endcase
        end
      end
      // Normalization of d into range and by the sign of f.
      sgcd_pkg::S_FIN1: res_r <= d_r[EXT_BITS-1] ? (d_r + m_r) : d_r;
      sgcd_pkg::S_FIN2: res_r <= fin_anti ? ('0 - res_r) : res_r;
      sgcd_pkg::S_FIN3: res_r <= res_r[EXT_BITS-1] ? (res_r + m_r) : res_r;
      sgcd_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_inverse_r <= fin_ok ? sgcd_pkg::FIELD_W'(res64[MOD_BITS-1:0]) : '0;
        end
      end
      default: ;
    endcase
  end

  // The multiply unit is only started when it is free.
  a_mac_free: assert property (@(posedge clk) disable iff (!rst_n)
    mac_req.start |-> !mac_st.busy)
    else $error("multiply started while busy");

  // The jump never runs more steps than its budget; the budget is loaded on round open.
  a_steps: assert property (@(posedge clk) disable iff (!rst_n)
    steps_r <= SW'(DIVSTEPS) || state_r == sgcd_pkg::S_IDLE || state_r == sgcd_pkg::S_RCHK)
    else $error("divstep budget overrun");

  // An accepted word always opens a round check.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == sgcd_pkg::S_RCHK)
    else $error("accepted word did not start");

  // A result is only loaded from the finishing state.
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == sgcd_pkg::S_DONE)
    else $error("result appeared outside the finishing state");

endmodule

### hw/rtl/sgcd_mac.sv
// Shared signed 64x64 multiply-accumulate unit built on one 32x32 multiplier.
`timescale 1ns / 1ps

module sgcd_mac (
  input  logic                           clk,
  input  logic                           rst_n,
  input  sgcd_pkg::sgcd_mac_req_t        req,
  output sgcd_pkg::sgcd_mac_st_t         st,
  output logic [sgcd_pkg::ACC_W-1:0]     acc
);

  logic [sgcd_pkg::WORD_W-1:0] a_r;
  logic [sgcd_pkg::WORD_W-1:0] b_r;
  logic [sgcd_pkg::ACC_W-1:0]  acc_r;
  sgcd_pkg::sgcd_mstep_t       step_r;
  logic                        busy_r;
  logic                        done_r;

  logic [sgcd_pkg::HALF_W-1:0] a_half;
  logic [sgcd_pkg::HALF_W-1:0] b_half;
  logic [sgcd_pkg::WORD_W-1:0] pp;
  logic [sgcd_pkg::ACC_W-1:0]  pp_shifted;
  logic [sgcd_pkg::WORD_W-1:0] corr;

  // Pick the halves for this partial product and place it.
  always_comb begin
    a_half = step_r[1] ? a_r[sgcd_pkg::WORD_W-1:sgcd_pkg::HALF_W]
                       : a_r[sgcd_pkg::HALF_W-1:0];
    b_half = step_r[0] ? b_r[sgcd_pkg::WORD_W-1:sgcd_pkg::HALF_W]
                       : b_r[sgcd_pkg::HALF_W-1:0];
    pp = sgcd_pkg::WORD_W'(a_half) * sgcd_pkg::WORD_W'(b_half);
    case (step_r)
      sgcd_pkg::M_LL: pp_shifted = sgcd_pkg::ACC_W'(pp);
      sgcd_pkg::M_LH, sgcd_pkg::M_HL:
        pp_shifted = sgcd_pkg::ACC_W'(pp) << sgcd_pkg::HALF_W;
      sgcd_pkg::M_HH: pp_shifted = sgcd_pkg::ACC_W'(pp) << sgcd_pkg::WORD_W;
      default: pp_shifted = '0;
    endcase
    // Signed correction of the unsigned product, applied to the high word.
    corr = (a_r[sgcd_pkg::WORD_W-1] ? (~b_r + 1'b1) : '0)
         + (b_r[sgcd_pkg::WORD_W-1] ? (~a_r + 1'b1) : '0);
  end

  // Step control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= sgcd_pkg::M_LL;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= sgcd_pkg::M_LL;
      end else if (busy_r) begin
        if (step_r == sgcd_pkg::M_CORR) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= sgcd_pkg::sgcd_mstep_t'(step_r + 3'd1);
        end
      end
    end
  end

  // Operands and accumulator.
  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r <= req.a;
      b_r <= req.b;
      if (req.clr) begin
        acc_r <= '0;
      end
    end else if (busy_r) begin
      if (step_r == sgcd_pkg::M_CORR) begin
        acc_r <= acc_r + {corr, {sgcd_pkg::WORD_W{1'b0}}};
      end else begin
        acc_r <= acc_r + pp_shifted;
      end
    end
  end

  assign st.busy = busy_r;
  assign st.done = done_r;
  assign acc = acc_r;

endmodule
